// ===== rtl/lidar_packet_deframer_unit_macros.svh =====
// Assertion helpers for the deframer.
`ifndef LIDAR_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define LIDAR_PACKET_DEFRAMER_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define LPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Types and constants shared by the packet deframer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lpd_pkg;
   localparam int FRAME_BYTES      = 22;
   localparam int POINTS_PER_FRAME = 4;
   localparam logic [7:0] START_BYTE = 8'hFA;
   localparam logic [7:0] INDEX_LOW  = 8'hA0;
   localparam logic [7:0] INDEX_HIGH = 8'hF9;
   localparam logic [1:0] KIND_POINT = 2'd0;
   localparam logic [1:0] KIND_REV   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;
   localparam logic [1:0] CSR_MIN_REV   = 2'd0;
   localparam logic [1:0] CSR_WRAP_HIGH = 2'd1;
   localparam logic [1:0] CSR_WRAP_LOW  = 2'd2;
   localparam logic [1:0] CSR_RESERVED  = 2'd3;
   localparam int SAT16 = 65535;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [8:0]  point_index;
      logic        point_valid;
      logic [13:0] range_mm;
      logic [15:0] intensity;
      logic [15:0] speed_raw;
      logic [15:0] rev_avg_speed_raw;
      logic [15:0] rev_valid_points;
      logic [15:0] rev_packets;
      logic [31:0] error_total;
      logic        last;
   } rsp_type;

   // Request from the sequencer to the divider.
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;
endpackage

// ===== rtl/lpd_if.sv =====
// ----------------------------------------------------------------------------
// lpd_req_if / lpd_rsp_if
// Valid/ready channels carrying received bytes and deframed results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface lpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpd_rsp_if import lpd_pkg::*; ;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lpd_divider.sv =====
// ----------------------------------------------------------------------------
// lpd_divider
// Restoring divider, one quotient bit per cycle, 32 by 16 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lpd_divider import lpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [31:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quo_ff[31]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Average never exceeds the largest speed, so the low half suffices.
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff[15:0];
endmodule

// ===== rtl/lidar_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// lidar_packet_deframer_unit
// Deframes 22-byte sensor packets into point, summary and error results.
// ----------------------------------------------------------------------------
// Usage: one serial byte per req transaction; results leave on rsp, one per
// transaction, with last set on the final result caused by a byte.
// Bytes are stored in a 22-entry frame memory (one write per byte). A byte
// that does not end a frame is taken while the block stays idle, so req.ready
// stays high. The final byte starts a sweep over the memory: 22 reads fold
// the checksum, a revolution boundary adds a serial division and a summary
// step, and each of the four points takes four memory reads and an emit step.
// A frame end keeps req.ready low for the whole sweep, which is serial because
// the frame memory has a single read port and the divider is serial.
// Each result waits in the output register until rsp.ready; the sequencer
// holds while it waits, so a stalled receiver stretches the sweep.
// req.ready returns after the last result of a frame is in the output register.
// Reset clears framing, the revolution counters, the error count and the
// configuration (10, 70, 10); the frame memory is not cleared.
// Configuration writes go through csr_. The user must write only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lidar_packet_deframer_unit_macros.svh"
module lidar_packet_deframer_unit import lpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lpd_req_if.sink    req,
   lpd_rsp_if.source  rsp,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_write_data
);
   localparam int AW = $clog2(FRAME_BYTES);

   localparam logic [3:0] S_IDLE = 4'd0, S_CK_RD = 4'd1, S_CK_END = 4'd2,
      S_HDR = 4'd3, S_DIV = 4'd4, S_SUM = 4'd5, S_PT = 4'd6, S_EMIT = 4'd7,
      S_ERR = 4'd8, S_DONE = 4'd9;

   logic [7:0]  mem [FRAME_BYTES];
   logic [7:0]  rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic        mem_we;
   logic [AW-1:0] wr_addr;

   logic [6:0]  min_rev_ff, wrap_hi_ff, wrap_lo_ff;
   logic        framing_ff, framing_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [6:0]  prev_idx_ff, prev_idx_in;
   logic        prev_known_ff, prev_known_in;
   logic [15:0] rev_pk_ff, rev_pk_in;
   logic [31:0] speed_sum_ff, speed_sum_in;
   logic [15:0] rev_pt_ff, rev_pt_in;
   logic [31:0] err_ff, err_in;

   logic [3:0]  st_ff, st_in;
   logic [AW:0] cnt_ff, cnt_in;          // read step counter within a sweep
   logic [31:0] ck_ff, ck_in;
   logic [7:0]  lo_ff, lo_in;            // low byte of a word being assembled
   logic [7:0]  idx_byte_ff, idx_byte_in;
   logic [15:0] speed_ff, speed_in;
   logic [15:0] ck_rx_ff, ck_rx_in;
   logic [1:0]  slot_ff, slot_in;
   logic [7:0]  pb0_ff, pb0_in, pb1_ff, pb1_in, pb2_ff, pb2_in, pb3_ff, pb3_in;
   logic [31:0] sum_snap_ff, sum_snap_in;
   logic [15:0] pk_snap_ff, pk_snap_in, pt_snap_ff, pt_snap_in;
   logic        out_v_ff, out_v_in;
   rsp_type     out_ff, out_in;
   logic [14:0] fold;
   logic [6:0]  idx7;
   logic        boundary;
   logic        accept;
   logic        vpt;
   div_req_type dreq;
   div_rsp_type drsp;

   lpd_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign accept    = req.valid && req.ready;
   assign req.ready = (st_ff == S_IDLE);
   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;
   assign idx7      = 7'(idx_byte_ff - INDEX_LOW);
   // Bits above 29 would only add multiples of 2^15 and vanish in the mask.
   assign fold      = 15'(ck_ff[14:0] + ck_ff[29:15]);
   assign boundary  = prev_known_ff && (prev_idx_ff >= wrap_hi_ff) &&
                      (idx7 <= wrap_lo_ff) && (rev_pk_ff >= 16'(min_rev_ff));
   assign vpt       = !pb1_ff[7];

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= req.rx_byte;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_rev_ff <= 7'd10;
         wrap_hi_ff <= 7'd70;
         wrap_lo_ff <= 7'd10;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_REV:   min_rev_ff <= csr_write_data;
            CSR_WRAP_HIGH: wrap_hi_ff <= csr_write_data;
            CSR_WRAP_LOW:  wrap_lo_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      framing_in = framing_ff; pos_in = pos_ff; prev_idx_in = prev_idx_ff;
      prev_known_in = prev_known_ff; rev_pk_in = rev_pk_ff;
      speed_sum_in = speed_sum_ff; rev_pt_in = rev_pt_ff; err_in = err_ff;
      st_in = st_ff; cnt_in = cnt_ff; ck_in = ck_ff; lo_in = lo_ff;
      idx_byte_in = idx_byte_ff; speed_in = speed_ff; ck_rx_in = ck_rx_ff;
      slot_in = slot_ff; pb0_in = pb0_ff; pb1_in = pb1_ff; pb2_in = pb2_ff;
      pb3_in = pb3_ff;
      sum_snap_in = sum_snap_ff; pk_snap_in = pk_snap_ff; pt_snap_in = pt_snap_ff;
      out_v_in = out_v_ff; out_in = out_ff;
      mem_we = 1'b0; wr_addr = pos_ff; rd_addr = '0;
      dreq = '0;
      if (out_v_ff && rsp.ready) out_v_in = 1'b0;

      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               if (!framing_ff) begin
                  if (req.rx_byte == START_BYTE) begin
                     mem_we = 1'b1; wr_addr = '0;
                     framing_in = 1'b1; pos_in = AW'(1);
                  end
               end else if (pos_ff == AW'(1) &&
                            (req.rx_byte < INDEX_LOW || req.rx_byte > INDEX_HIGH)) begin
                  framing_in = 1'b0; pos_in = '0;
                  if (req.rx_byte == START_BYTE) begin
                     mem_we = 1'b1; wr_addr = '0;
                     framing_in = 1'b1; pos_in = AW'(1);
                  end
               end else begin
                  mem_we = 1'b1;
                  if (pos_ff == AW'(FRAME_BYTES - 1)) begin
                     framing_in = 1'b0; pos_in = '0;
                     st_in = S_CK_RD; cnt_in = '0; ck_in = '0;
                  end else begin
                     pos_in = pos_ff + AW'(1);
                  end
               end
            end
         end
         // Read address cnt is issued; data of cnt-1 arrives this cycle.
         S_CK_RD: begin
            if (cnt_ff < (AW+1)'(FRAME_BYTES)) rd_addr = cnt_ff[AW-1:0];
            if (cnt_ff != '0) begin
               if (!cnt_ff[0]) begin
                  if (cnt_ff <= (AW+1)'(FRAME_BYTES - 2))
                     ck_in = {ck_ff[30:0], 1'b0} + {16'd0, rd_data_ff, lo_ff};
                  else
                     ck_rx_in = {rd_data_ff, lo_ff};
               end else begin
                  lo_in = rd_data_ff;
               end
               if (cnt_ff == (AW+1)'(2)) idx_byte_in = rd_data_ff;
               if (cnt_ff == (AW+1)'(4)) speed_in = {rd_data_ff, lo_ff};
            end
            if (cnt_ff == (AW+1)'(FRAME_BYTES)) st_in = S_CK_END;
            else cnt_in = cnt_ff + (AW+1)'(1);
         end
         S_CK_END: begin
            if (fold == ck_rx_ff[14:0] && !ck_rx_ff[15]) st_in = S_HDR;
            else st_in = S_ERR;
         end
         S_ERR: begin
            if (!out_v_ff || rsp.ready) begin
               err_in = err_ff + 32'd1;
               out_in = '0;
               out_in.result_kind = KIND_ERROR;
               out_in.error_total = err_ff + 32'd1;
               out_in.last = 1'b1;
               out_v_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         S_HDR: begin
            sum_snap_in = speed_sum_ff; pk_snap_in = rev_pk_ff; pt_snap_in = rev_pt_ff;
            if (boundary) begin
               dreq.start = (rev_pk_ff != 16'd0);
               dreq.dividend = speed_sum_ff;
               dreq.divisor = rev_pk_ff;
               rev_pk_in = 16'd1; speed_sum_in = {16'd0, speed_ff}; rev_pt_in = '0;
               st_in = (rev_pk_ff != 16'd0) ? S_DIV : S_SUM;
            end else begin
               if (rev_pk_ff != 16'(SAT16)) begin
                  rev_pk_in = rev_pk_ff + 16'd1;
                  speed_sum_in = speed_sum_ff + {16'd0, speed_ff};
               end
               st_in = S_PT;
            end
            prev_idx_in = idx7; prev_known_in = 1'b1;
            slot_in = '0; cnt_in = '0;
         end
         S_DIV: begin
            if (drsp.done) begin
               sum_snap_in = {16'd0, drsp.quotient};
               st_in = S_SUM;
            end
         end
         S_SUM: begin
            if (!out_v_ff || rsp.ready) begin
               out_in = '0;
               out_in.result_kind = KIND_REV;
               out_in.rev_avg_speed_raw = (pk_snap_ff == 16'd0) ? 16'd0 : sum_snap_ff[15:0];
               out_in.rev_valid_points = pt_snap_ff;
               out_in.rev_packets = pk_snap_ff;
               out_v_in = 1'b1;
               st_in = S_PT; cnt_in = '0;
            end
         end
         // Four reads of point bytes: offset 4+4*slot+cnt.
         S_PT: begin
            rd_addr = AW'(5'd4 + {1'b0, slot_ff, 2'b00} + 5'(cnt_ff[1:0]));
            if (cnt_ff == (AW+1)'(1)) pb0_in = rd_data_ff;
            if (cnt_ff == (AW+1)'(2)) pb1_in = rd_data_ff;
            if (cnt_ff == (AW+1)'(3)) pb2_in = rd_data_ff;
            if (cnt_ff == (AW+1)'(4)) begin
               pb3_in = rd_data_ff;
               st_in = S_EMIT;
            end else begin
               cnt_in = cnt_ff + (AW+1)'(1);
            end
         end
         S_EMIT: begin
            if (!out_v_ff || rsp.ready) begin
               out_in = '0;
               out_in.result_kind = KIND_POINT;
               out_in.point_index = 9'({2'b00, idx7} * 9'd4 + 9'(slot_ff));
               out_in.speed_raw = speed_ff;
               if (vpt) begin
                  out_in.point_valid = 1'b1;
                  out_in.range_mm = {pb1_ff[5:0], pb0_ff};
                  out_in.intensity = {pb3_ff, pb2_ff};
                  if (rev_pt_ff != 16'(SAT16)) rev_pt_in = rev_pt_ff + 16'd1;
               end
               out_in.last = (slot_ff == 2'(POINTS_PER_FRAME - 1));
               out_v_in = 1'b1;
               cnt_in = '0;
               if (slot_ff == 2'(POINTS_PER_FRAME - 1)) st_in = S_DONE;
               else begin
                  slot_in = slot_ff + 2'd1;
                  st_in = S_PT;
               end
            end
         end
         S_DONE: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in; ck_ff <= ck_in; lo_ff <= lo_in; idx_byte_ff <= idx_byte_in;
      speed_ff <= speed_in; ck_rx_ff <= ck_rx_in; slot_ff <= slot_in;
      pb0_ff <= pb0_in; pb1_ff <= pb1_in; pb2_ff <= pb2_in; pb3_ff <= pb3_in;
      sum_snap_ff <= sum_snap_in; pk_snap_ff <= pk_snap_in; pt_snap_ff <= pt_snap_in;
      out_ff <= out_in;
      if (reset) begin
         framing_ff <= 1'b0; pos_ff <= '0; prev_idx_ff <= '0; prev_known_ff <= 1'b0;
         rev_pk_ff <= '0; speed_sum_ff <= '0; rev_pt_ff <= '0; err_ff <= '0;
         st_ff <= S_IDLE; out_v_ff <= 1'b0;
      end else begin
         framing_ff <= framing_in; pos_ff <= pos_in; prev_idx_ff <= prev_idx_in;
         prev_known_ff <= prev_known_in; rev_pk_ff <= rev_pk_in;
         speed_sum_ff <= speed_sum_in; rev_pt_ff <= rev_pt_in; err_ff <= err_in;
         st_ff <= st_in; out_v_ff <= out_v_in;
      end
   end

   `LPD_ASSERT_IMP(a_pos_range, clock, reset, 1'b1, pos_ff < AW'(FRAME_BYTES), "position out of range")
   `LPD_ASSERT_NEXT(a_hold, clock, reset, out_v_ff && !rsp.ready, out_v_ff && $stable(out_ff), "result dropped")
   `LPD_ASSERT_IMP(a_kind, clock, reset, out_v_ff, out_ff.result_kind <= KIND_ERROR, "bad kind")
   `LPD_ASSERT_IMP(a_pt_cnt, clock, reset, st_ff == S_PT, cnt_ff <= (AW+1)'(4), "point read step out of range")
endmodule

// ===== tb/lidar_packet_deframer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// tb_lidar_packet_deframer_unit
// Drives serial bytes into the packet deframer and checks every result against
// an independent model of framing, checksum, revolution and error handling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import lpd_pkg::*;

class deframe_scoreboard;
   // Configuration and state mirrored from the block.
   logic [6:0]  min_rev;
   logic [6:0]  wrap_high;
   logic [6:0]  wrap_low;
   bit          framing;
   int          position;
   logic [7:0]  frame [22];
   logic [6:0]  prev_idx;
   bit          prev_known;
   logic [15:0] rev_pkts;
   logic [31:0] speed_acc;
   logic [15:0] rev_points;
   logic [31:0] crc_failures;
   rsp_type     pending [$];
   int          mismatches;

   function new();
      min_rev = 10;
      wrap_high = 70;
      wrap_low = 10;
      framing = 0;
      position = 0;
      prev_idx = 0;
      prev_known = 0;
      rev_pkts = 0;
      speed_acc = 0;
      rev_points = 0;
      crc_failures = 0;
      mismatches = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [6:0] value);
      if (idx == CSR_MIN_REV) min_rev = value;
      else if (idx == CSR_WRAP_HIGH) wrap_high = value;
      else if (idx == CSR_WRAP_LOW) wrap_low = value;
   endfunction

   function logic [15:0] word_at(int pos);
      return {frame[pos + 1], frame[pos]};
   endfunction

   function void emit_packet();
      logic [31:0] fold;
      logic [6:0]  idx;
      logic [15:0] speed;
      rsp_type     r;
      fold = 0;
      for (int i = 0; i < 20; i += 2) fold = (fold << 1) + word_at(i);
      fold = ((fold & 32'h7FFF) + (fold >> 15)) & 32'h7FFF;
      if (fold[15:0] != word_at(20)) begin
         crc_failures++;
         r = '0;
         r.result_kind = KIND_ERROR;
         r.error_total = crc_failures;
         r.last = 1;
         pending.push_back(r);
         return;
      end
      idx = 7'(frame[1] - INDEX_LOW);
      speed = word_at(2);
      if (prev_known && prev_idx >= wrap_high && idx <= wrap_low && rev_pkts >= min_rev) begin
         r = '0;
         r.result_kind = KIND_REV;
         r.rev_avg_speed_raw = (rev_pkts != 0) ? 16'(speed_acc / rev_pkts) : 16'd0;
         r.rev_valid_points = rev_points;
         r.rev_packets = rev_pkts;
         pending.push_back(r);
         rev_pkts = 0;
         speed_acc = 0;
         rev_points = 0;
      end
      prev_idx = idx;
      prev_known = 1;
      if (rev_pkts != 16'hFFFF) begin
         rev_pkts++;
         speed_acc += speed;
      end
      for (int j = 0; j < 4; j++) begin
         r = '0;
         r.result_kind = KIND_POINT;
         r.point_index = 9'(idx * 4 + j);
         r.speed_raw = speed;
         if (!frame[5 + 4 * j][7]) begin
            r.point_valid = 1;
            r.range_mm = {frame[5 + 4 * j][5:0], frame[4 + 4 * j]};
            r.intensity = word_at(6 + 4 * j);
            if (rev_points != 16'hFFFF) rev_points++;
         end
         r.last = (j == 3);
         pending.push_back(r);
      end
   endfunction

   function void note_byte(logic [7:0] b);
      if (!framing) begin
         if (b == START_BYTE) begin
            framing = 1;
            frame[0] = b;
            position = 1;
         end
         return;
      end
      frame[position] = b;
      position++;
      if (position == 2 && (b < INDEX_LOW || b > INDEX_HIGH)) begin
         framing = (b == START_BYTE);
         position = framing ? 1 : 0;
         return;
      end
      if (position >= 22) begin
         framing = 0;
         position = 0;
         emit_packet();
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) $display("Result mismatch: expected %p actual %p", want, got);
      end
   endfunction
endclass

module tb_lidar_packet_deframer_unit;
   localparam int CYCLE_LIMIT = 2000000;

   logic       clock = 0;
   logic       reset = 1;
   logic       csr_write_enable = 0;
   logic [1:0] csr_index = CSR_MIN_REV;
   logic [6:0] csr_write_data = 0;
   int         cycles = 0;
   bit         feed_done = 0;

   lpd_req_if req ();
   lpd_rsp_if rsp ();
   deframe_scoreboard board = new();

   lidar_packet_deframer_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 0;
      req.rx_byte = 0;
      rsp.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset && req.valid && req.ready) board.note_byte(req.rx_byte);
      if (!reset && rsp.valid && rsp.ready) board.check_result(rsp.data);
   end

   // The receiver stalls for a random gap, possibly none, before each transaction.
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp.ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp.ready <= 1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Leaves valid high after the transaction; idle_req or a later call with a gap drops it.
   task automatic send_byte(input logic [7:0] b, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1;
      req.rx_byte <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_req();
      req.valid <= 0;
   endtask

   task automatic wait_idle();
      idle_req();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      board.write_reg(idx, value);
      @(negedge clock);
      csr_write_enable <= 0;
      @(negedge clock);
   endtask

   // Sends one packet; bad_crc corrupts its checksum word.
   task automatic send_packet(input logic [6:0] idx, input logic [15:0] speed,
                              input bit bad_crc, input bit burst);
      logic [7:0]  bytes [22];
      logic [31:0] fold;
      bytes[0] = START_BYTE;
      bytes[1] = INDEX_LOW + idx;
      bytes[2] = speed[7:0];
      bytes[3] = speed[15:8];
      for (int i = 4; i < 20; i++) bytes[i] = 8'($urandom);
      fold = 0;
      for (int i = 0; i < 20; i += 2) fold = (fold << 1) + {bytes[i + 1], bytes[i]};
      fold = ((fold & 32'h7FFF) + (fold >> 15)) & 32'h7FFF;
      if (bad_crc) fold = fold ^ (32'h1 << $urandom_range(0, 15));
      bytes[20] = fold[7:0];
      bytes[21] = fold[15:8];
      for (int i = 0; i < 22; i++) send_byte(bytes[i], burst);
   endtask

   initial begin
      int sent;
      bit reconfigured;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed part: hunting noise, bad indexes, extreme fields, checksum errors.
      send_byte(8'h00, 0);
      send_byte(8'hFF, 0);
      send_byte(START_BYTE, 0);
      send_byte(8'h9F, 0);
      send_byte(START_BYTE, 0);
      send_byte(START_BYTE, 0);
      send_byte(8'hFA, 0);
      send_packet(7'd89, 16'hFFFF, 0, 0);
      send_packet(7'd0, 16'h0000, 0, 0);
      send_packet(7'd45, 16'h1234, 1, 1);
      wait_idle();

      // Revolution boundaries with min_rev 0 and extreme wrap settings.
      write_reg(CSR_MIN_REV, 7'd0);
      write_reg(CSR_WRAP_HIGH, 7'd0);
      write_reg(CSR_WRAP_LOW, 7'd89);
      write_reg(CSR_RESERVED, 7'h7F);
      for (int k = 0; k < 6; k++) send_packet(7'($urandom_range(0, 89)), 16'($urandom), 0, 1);
      wait_idle();

      write_reg(CSR_MIN_REV, 7'd90);
      write_reg(CSR_WRAP_HIGH, 7'd89);
      write_reg(CSR_WRAP_LOW, 7'd0);
      send_packet(7'd89, 16'hFFFF, 0, 0);
      send_packet(7'd0, 16'd1, 0, 0);
      wait_idle();

      // Random part: mostly rotating packet streams, some noise and errors.
      write_reg(CSR_MIN_REV, 7'd2);
      write_reg(CSR_WRAP_HIGH, 7'd6);
      write_reg(CSR_WRAP_LOW, 7'd1);
      sent = 0;
      reconfigured = 0;
      while (sent < 60) begin
         int pick;
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            send_packet(7'(sent % 8), 16'($urandom), $urandom_range(0, 7) == 0,
                        $urandom_range(0, 2) == 0);
            sent += 22;
         end else if (pick < 9) begin
            send_byte(8'($urandom), 0);
            sent++;
         end else begin
            send_byte(START_BYTE, 0);
            send_byte(8'($urandom), 0);
            sent += 2;
         end
         if (!reconfigured && sent > 30) begin
            wait_idle();
            write_reg(CSR_MIN_REV, 7'($urandom_range(0, 4)));
            write_reg(CSR_WRAP_HIGH, 7'($urandom_range(0, 7)));
            write_reg(CSR_WRAP_LOW, 7'($urandom_range(0, 3)));
            reconfigured = 1;
         end
      end
      idle_req();
      feed_done = 1;
   end

   initial begin
      wait (feed_done);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lpd_pkg.sv
rtl/lpd_if.sv
rtl/lpd_divider.sv
rtl/lidar_packet_deframer_unit.sv
tb/lidar_packet_deframer_unit_tb.sv
